@@ hw/rtl/intc_pkg.sv @@
// Shared types and constants for the intcode processor core.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package intc_pkg;

    localparam int MEM_WORDS  = 4096;
    localparam int ADDR_W     = $clog2(MEM_WORDS);
    localparam int WORD_W     = 64;
    localparam int BCD_DIGITS = 5;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int BITS_PER_DABBLE = 8;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_STEP = 1'b1;

    typedef enum logic [2:0] {
        ST_RUN    = 3'd0,
        ST_WAIT   = 3'd1,
        ST_HALT   = 3'd2,
        ST_OPCODE = 3'd3,
        ST_MODE   = 3'd4,
        ST_RANGE  = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        OPC_ADD  = 4'd0,
        OPC_MUL  = 4'd1,
        OPC_IN   = 4'd2,
        OPC_OUT  = 4'd3,
        OPC_JNZ  = 4'd4,
        OPC_JZ   = 4'd5,
        OPC_LT   = 4'd6,
        OPC_EQ   = 4'd7,
        OPC_ARB  = 4'd8,
        OPC_HALT = 4'd9,
        OPC_BAD  = 4'd10
    } opc_t;

    typedef enum logic [3:0] {
        OP_NONE    = 4'd0,
        OP_CLEAR   = 4'd1,
        OP_CAPTURE = 4'd2,
        OP_LOAD    = 4'd3,
        OP_FETCH   = 4'd4,
        OP_WORD    = 4'd5,
        OP_DABBLE  = 4'd6,
        OP_SLOT    = 4'd7,
        OP_PARAM   = 4'd8,
        OP_VALUE   = 4'd9,
        OP_MUL     = 4'd10,
        OP_COMMIT  = 4'd11,
        OP_RESPOND = 4'd12
    } dp_op_t;

    typedef struct packed {
        logic               mode;
        logic [11:0]        load_address;
        logic signed [63:0] load_value;
        logic signed [63:0] input_value;
        logic               input_valid;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic               output_valid;
        logic signed [63:0] output_value;
        logic signed [63:0] program_counter;
    } rsp_t;

    typedef struct packed {
        dp_op_t  op;
        logic [1:0] opnd;
        logic    wr;
        logic    set_status;
        status_t code;
    } dp_cmd_t;

    typedef struct packed {
        logic is_load;
        logic runnable;
        logic ip_ok;
        logic word_neg;
        logic dabble_last;
        opc_t opc;
        logic input_ok;
        logic mode_bad;
        logic slot_ok;
        logic addr_ok;
        logic digit_imm;
        logic take;
        logic mul_last;
        logic clr_last;
        logic out_busy;
    } dp_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/intc_ram.sv @@
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module intc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hw/rtl/intc_ctrl.sv @@
// Controller state machine: sequences fetch, decode, operands and commit.
// Depends on intc_pkg.
`default_nettype none

module intc_ctrl
    import intc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [12:0] {
        S_CLEAR    = 13'b0000000000001,
        S_IDLE     = 13'b0000000000010,
        S_DISPATCH = 13'b0000000000100,
        S_WORD     = 13'b0000000001000,
        S_DECODE   = 13'b0000000010000,
        S_EXEC     = 13'b0000000100000,
        S_OPND     = 13'b0000001000000,
        S_PARAM    = 13'b0000010000000,
        S_VALUE    = 13'b0000100000000,
        S_NEXT     = 13'b0001000000000,
        S_MUL      = 13'b0010000000000,
        S_COMMIT   = 13'b0100000000000,
        S_RESPOND  = 13'b1000000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] opnd_reg, opnd_next;
    logic       wr_reg, wr_next;

    always_comb
    begin
        state_next     = state_reg;
        opnd_next      = opnd_reg;
        wr_next        = wr_reg;
        cmd.op         = OP_NONE;
        cmd.opnd       = opnd_reg;
        cmd.wr         = wr_reg;
        cmd.set_status = 1'b0;
        cmd.code       = ST_RUN;
        req_ready      = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                cmd.op = OP_CLEAR;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.op     = OP_CAPTURE;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.is_load)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_RESPOND;
                end
                else if (!stat.runnable)
                begin
                    state_next = S_RESPOND;
                end
                else if (!stat.ip_ok)
                begin
                    cmd.set_status = 1'b1;
                    cmd.code       = ST_RANGE;
                    state_next     = S_RESPOND;
                end
                else
                begin
                    cmd.op     = OP_FETCH;
                    state_next = S_WORD;
                end
            end
            S_WORD:
            begin
                cmd.op     = OP_WORD;
                state_next = S_DECODE;
            end
            S_DECODE:
            begin
                if (stat.word_neg)
                begin
                    cmd.set_status = 1'b1;
                    cmd.code       = ST_OPCODE;
                    state_next     = S_RESPOND;
                end
                else
                begin
                    cmd.op = OP_DABBLE;
                    if (stat.dabble_last)
                    begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_EXEC:
            begin
                opnd_next = 2'd0;
                wr_next   = 1'b0;
                case (stat.opc)
                    OPC_BAD:
                    begin
                        cmd.set_status = 1'b1;
                        cmd.code       = ST_OPCODE;
                        state_next     = S_RESPOND;
                    end
                    OPC_HALT:
                    begin
                        cmd.set_status = 1'b1;
                        cmd.code       = ST_HALT;
                        state_next     = S_RESPOND;
                    end
                    OPC_IN:
                    begin
                        if (!stat.input_ok)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.code       = ST_WAIT;
                            state_next     = S_RESPOND;
                        end
                        else
                        begin
                            wr_next    = 1'b1;
                            state_next = S_OPND;
                        end
                    end
                    default:
                    begin
                        state_next = S_OPND;
                    end
                endcase
            end
            S_OPND:
            begin
                if (stat.mode_bad)
                begin
                    cmd.set_status = 1'b1;
                    cmd.code       = ST_MODE;
                    state_next     = S_RESPOND;
                end
                else if (!stat.slot_ok)
                begin
                    cmd.set_status = 1'b1;
                    cmd.code       = ST_RANGE;
                    state_next     = S_RESPOND;
                end
                else
                begin
                    cmd.op     = OP_SLOT;
                    state_next = S_PARAM;
                end
            end
            S_PARAM:
            begin
                cmd.op = OP_PARAM;
                if (!stat.addr_ok)
                begin
                    cmd.set_status = 1'b1;
                    cmd.code       = ST_RANGE;
                    state_next     = S_RESPOND;
                end
                else if (wr_reg || stat.digit_imm)
                begin
                    state_next = S_NEXT;
                end
                else
                begin
                    state_next = S_VALUE;
                end
            end
            S_VALUE:
            begin
                cmd.op     = OP_VALUE;
                state_next = S_NEXT;
            end
            S_NEXT:
            begin
                case (stat.opc)
                    OPC_ADD, OPC_MUL, OPC_LT, OPC_EQ:
                    begin
                        if (opnd_reg == 2'd0)
                        begin
                            opnd_next  = 2'd1;
                            state_next = S_OPND;
                        end
                        else if (opnd_reg == 2'd1)
                        begin
                            opnd_next  = 2'd2;
                            wr_next    = 1'b1;
                            state_next = S_OPND;
                        end
                        else if (stat.opc == OPC_MUL)
                        begin
                            state_next = S_MUL;
                        end
                        else
                        begin
                            state_next = S_COMMIT;
                        end
                    end
                    OPC_JNZ, OPC_JZ:
                    begin
                        // The target is decoded only when the jump is taken.
                        if (opnd_reg == 2'd0 && stat.take)
                        begin
                            opnd_next  = 2'd1;
                            state_next = S_OPND;
                        end
                        else
                        begin
                            state_next = S_COMMIT;
                        end
                    end
                    default:
                    begin
                        state_next = S_COMMIT;
                    end
                endcase
            end
            S_MUL:
            begin
                cmd.op = OP_MUL;
                if (stat.mul_last)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                cmd.op     = OP_COMMIT;
                state_next = S_RESPOND;
            end
            S_RESPOND:
            begin
                if (!stat.out_busy)
                begin
                    cmd.op     = OP_RESPOND;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            opnd_reg  <= 2'd0;
            wr_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            opnd_reg  <= opnd_next;
            wr_reg    <= wr_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/intc_dp.sv @@
// Datapath: word memory, architectural registers, decimal decode,
// operand addressing, shared 32x32 multiplier and the response register.
// Depends on intc_pkg and intc_ram.
`default_nettype none

module intc_dp
    import intc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  req_t     req_data,
    input  dp_cmd_t  cmd,
    output dp_stat_t stat,
    input  logic     rsp_ready,
    output logic     rsp_valid,
    output rsp_t     rsp_data
);

    localparam logic [WORD_W-1:0] MEM_LIMIT = WORD_W'(MEM_WORDS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MEM_WORDS - 1);

    // Double dabble over one byte; only the low five decimal digits are kept,
    // which yields the word modulo 100000.
    function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] bcd_in,
                                                 input logic [BITS_PER_DABBLE-1:0] bits);
        logic [BCD_W-1:0] v;
        v = bcd_in;
        for (int i = BITS_PER_DABBLE - 1; i >= 0; i--)
        begin
            for (int d = 0; d < BCD_DIGITS; d++)
            begin
                if (v[4*d +: 4] >= 4'd5)
                begin
                    v[4*d +: 4] = v[4*d +: 4] + 4'd3;
                end
            end
            v = {v[BCD_W-2:0], bits[i]};
        end
        return v;
    endfunction

    req_t              item_reg, item_next;
    logic [WORD_W-1:0] ip_reg, ip_next;
    logic [WORD_W-1:0] rb_reg, rb_next;
    status_t           mst_reg, mst_next;
    logic [WORD_W-1:0] sh_reg, sh_next;
    logic              neg_reg, neg_next;
    logic [BCD_W-1:0]  bcd_reg, bcd_next;
    logic [2:0]        dcnt_reg, dcnt_next;
    logic [WORD_W-1:0] a_reg, a_next;
    logic [WORD_W-1:0] b_reg, b_next;
    logic [ADDR_W-1:0] t_reg, t_next;
    logic [WORD_W-1:0] prod_reg, prod_next;
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [1:0]        mcnt_reg, mcnt_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic              ov_reg, ov_next;
    logic [WORD_W-1:0] oval_reg, oval_next;
    logic              outv_reg, outv_next;
    rsp_t              rsp_reg, rsp_next;

    logic              mem_en;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [WORD_W-1:0] mem_wdata;
    logic [WORD_W-1:0] mem_rdata;

    logic [3:0]        digit;
    logic [WORD_W-1:0] slot;
    logic [WORD_W-1:0] opnd_addr;
    logic [WORD_W-1:0] load_addr;
    logic [WORD_W-1:0] result;
    logic [31:0]       mul_x;
    logic [31:0]       mul_y;
    logic [WORD_W-1:0] mul_p;
    opc_t              opc;
    logic              take;

    intc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MEM_WORDS)
    ) u_ram (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        case (cmd.opnd)
            2'd0:    digit = bcd_reg[11:8];
            2'd1:    digit = bcd_reg[15:12];
            default: digit = bcd_reg[19:16];
        endcase
    end

    always_comb
    begin
        opc = OPC_BAD;
        if (bcd_reg[7:0] == 8'h99)
        begin
            opc = OPC_HALT;
        end
        else if (bcd_reg[7:4] == 4'd0)
        begin
            case (bcd_reg[3:0])
                4'd1:    opc = OPC_ADD;
                4'd2:    opc = OPC_MUL;
                4'd3:    opc = OPC_IN;
                4'd4:    opc = OPC_OUT;
                4'd5:    opc = OPC_JNZ;
                4'd6:    opc = OPC_JZ;
                4'd7:    opc = OPC_LT;
                4'd8:    opc = OPC_EQ;
                4'd9:    opc = OPC_ARB;
                default: opc = OPC_BAD;
            endcase
        end
    end

    assign slot      = ip_reg + WORD_W'(cmd.opnd) + WORD_W'(1);
    assign load_addr = WORD_W'(item_reg.load_address);
    assign take      = (opc == OPC_JNZ) ? (a_reg != '0) : (a_reg == '0);

    always_comb
    begin
        case (digit)
            4'd1:    opnd_addr = slot;
            4'd2:    opnd_addr = rb_reg + mem_rdata;
            default: opnd_addr = mem_rdata;
        endcase
    end

    always_comb
    begin
        case (mcnt_reg)
            2'd0:
            begin
                mul_x = a_reg[31:0];
                mul_y = b_reg[31:0];
            end
            2'd1:
            begin
                mul_x = a_reg[31:0];
                mul_y = b_reg[63:32];
            end
            default:
            begin
                mul_x = a_reg[63:32];
                mul_y = b_reg[31:0];
            end
        endcase
        mul_p = WORD_W'(mul_x) * WORD_W'(mul_y);
    end

    always_comb
    begin
        case (opc)
            OPC_ADD: result = a_reg + b_reg;
            OPC_MUL: result = acc_reg;
            OPC_LT:  result = WORD_W'($signed(a_reg) < $signed(b_reg));
            OPC_EQ:  result = WORD_W'(a_reg == b_reg);
            default: result = item_reg.input_value;
        endcase
    end

    always_comb
    begin
        stat.is_load     = (item_reg.mode == MODE_LOAD);
        stat.runnable    = (mst_reg == ST_RUN) || (mst_reg == ST_WAIT);
        stat.ip_ok       = (ip_reg < MEM_LIMIT);
        stat.word_neg    = neg_reg;
        stat.dabble_last = (dcnt_reg == 3'd7);
        stat.opc         = opc;
        stat.input_ok    = item_reg.input_valid;
        stat.mode_bad    = (digit > 4'd2) || (digit == 4'd1 && cmd.wr);
        stat.slot_ok     = (slot < MEM_LIMIT);
        stat.addr_ok     = (opnd_addr < MEM_LIMIT);
        stat.digit_imm   = (digit == 4'd1);
        stat.take        = take;
        stat.mul_last    = (mcnt_reg == 2'd3);
        stat.clr_last    = (clr_reg == LAST_ADDR);
        stat.out_busy    = outv_reg && !rsp_ready;
    end

    always_comb
    begin
        item_next = item_reg;
        ip_next   = ip_reg;
        rb_next   = rb_reg;
        mst_next  = mst_reg;
        sh_next   = sh_reg;
        neg_next  = neg_reg;
        bcd_next  = bcd_reg;
        dcnt_next = dcnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        t_next    = t_reg;
        prod_next = prod_reg;
        acc_next  = acc_reg;
        mcnt_next = mcnt_reg;
        clr_next  = clr_reg;
        ov_next   = ov_reg;
        oval_next = oval_reg;
        outv_next = outv_reg && !rsp_ready;
        rsp_next  = rsp_reg;
        mem_en    = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = ip_reg[ADDR_W-1:0];
        mem_wdata = '0;

        case (cmd.op)
            OP_CLEAR:
            begin
                mem_en   = 1'b1;
                mem_we   = 1'b1;
                mem_addr = clr_reg;
                clr_next = clr_reg + ADDR_W'(1);
            end
            OP_CAPTURE:
            begin
                item_next = req_data;
                ov_next   = 1'b0;
                oval_next = '0;
            end
            OP_LOAD:
            begin
                mem_en    = 1'b1;
                mem_we    = (load_addr < MEM_LIMIT);
                mem_addr  = load_addr[ADDR_W-1:0];
                mem_wdata = item_reg.load_value;
            end
            OP_FETCH:
            begin
                mem_en = 1'b1;
            end
            OP_WORD:
            begin
                sh_next   = mem_rdata;
                neg_next  = mem_rdata[WORD_W-1];
                bcd_next  = '0;
                dcnt_next = 3'd0;
            end
            OP_DABBLE:
            begin
                bcd_next  = dabble(bcd_reg, sh_reg[WORD_W-1 -: BITS_PER_DABBLE]);
                sh_next   = sh_reg << BITS_PER_DABBLE;
                dcnt_next = dcnt_reg + 3'd1;
            end
            OP_SLOT:
            begin
                mem_en   = 1'b1;
                mem_addr = slot[ADDR_W-1:0];
            end
            OP_PARAM:
            begin
                if (cmd.wr)
                begin
                    t_next = opnd_addr[ADDR_W-1:0];
                end
                else if (digit == 4'd1)
                begin
                    if (cmd.opnd == 2'd0)
                    begin
                        a_next = mem_rdata;
                    end
                    else
                    begin
                        b_next = mem_rdata;
                    end
                end
                else
                begin
                    mem_en   = 1'b1;
                    mem_addr = opnd_addr[ADDR_W-1:0];
                end
            end
            OP_VALUE:
            begin
                if (cmd.opnd == 2'd0)
                begin
                    a_next = mem_rdata;
                end
                else
                begin
                    b_next = mem_rdata;
                end
            end
            OP_MUL:
            begin
                // Low 64 bits of the product from three 32x32 partial products.
                prod_next = mul_p;
                mcnt_next = mcnt_reg + 2'd1;
                case (mcnt_reg)
                    2'd0:    acc_next = '0;
                    2'd1:    acc_next = prod_reg;
                    default: acc_next = acc_reg + {prod_reg[31:0], 32'd0};
                endcase
            end
            OP_COMMIT:
            begin
                mst_next = ST_RUN;
                case (opc)
                    OPC_ADD, OPC_MUL, OPC_LT, OPC_EQ:
                    begin
                        mem_en    = 1'b1;
                        mem_we    = 1'b1;
                        mem_addr  = t_reg;
                        mem_wdata = result;
                        ip_next   = ip_reg + WORD_W'(4);
                    end
                    OPC_IN:
                    begin
                        mem_en    = 1'b1;
                        mem_we    = 1'b1;
                        mem_addr  = t_reg;
                        mem_wdata = result;
                        ip_next   = ip_reg + WORD_W'(2);
                    end
                    OPC_OUT:
                    begin
                        ov_next   = 1'b1;
                        oval_next = a_reg;
                        ip_next   = ip_reg + WORD_W'(2);
                    end
                    OPC_JNZ, OPC_JZ:
                    begin
                        ip_next = take ? b_reg : ip_reg + WORD_W'(3);
                    end
                    OPC_ARB:
                    begin
                        rb_next = rb_reg + a_reg;
                        ip_next = ip_reg + WORD_W'(2);
                    end
                    default:
                    begin
                        mst_next = mst_reg;
                    end
                endcase
            end
            OP_RESPOND:
            begin
                outv_next                = 1'b1;
                rsp_next.status          = mst_reg;
                rsp_next.output_valid    = ov_reg;
                rsp_next.output_value    = oval_reg;
                rsp_next.program_counter = ip_reg;
            end
            default:
            begin
                mem_en = 1'b0;
            end
        endcase

        if (cmd.set_status)
        begin
            mst_next = cmd.code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ip_reg   <= '0;
            rb_reg   <= '0;
            mst_reg  <= ST_RUN;
            dcnt_reg <= '0;
            mcnt_reg <= '0;
            clr_reg  <= '0;
            outv_reg <= 1'b0;
        end
        else
        begin
            ip_reg   <= ip_next;
            rb_reg   <= rb_next;
            mst_reg  <= mst_next;
            dcnt_reg <= dcnt_next;
            mcnt_reg <= mcnt_next;
            clr_reg  <= clr_next;
            outv_reg <= outv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        sh_reg   <= sh_next;
        neg_reg  <= neg_next;
        bcd_reg  <= bcd_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        t_reg    <= t_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        ov_reg   <= ov_next;
        oval_reg <= oval_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_valid = outv_reg;
    assign rsp_data  = rsp_reg;

endmodule

`default_nettype wire

@@ hw/rtl/intcode_processor_core_top.sv @@
// Top level of the intcode processor core: controller plus datapath.
// Depends on intc_pkg, intc_ctrl, intc_dp (which holds intc_ram).
//
//   Channel  | Handshake             | Payload
//   ---------+-----------------------+------------------------------
//   request  | req_valid / req_ready | req_data (mode, load, input)
//   response | rsp_valid / rsp_ready | rsp_data (status, output, pc)
//
// One request at a time. A load writes its word, then responds; a step
// fetches the word and decodes it to decimal a byte at a time, reads each
// operand on the single-port word memory (one slot read and at most one
// value read), does mul as three partial products, then commits, responds.
// After reset the memory is swept to zero, all 4096 words; req_ready is low.
// A finished response waits in the output register while the next request
// is accepted; the core stalls only if a second response is ready first.
`default_nettype none

module intcode_processor_core_top
    import intc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req_data,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    intc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    intc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_ready (rsp_ready),
        .rsp_valid (rsp_valid),
        .rsp_data  (rsp_data)
    );

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_RESPOND |-> (!rsp_valid || rsp_ready))
        else $error("response register overwritten before it was taken");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while another is in progress");

    a_fault_code: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.set_status |-> cmd.code != ST_RUN)
        else $error("status forced to running by a fault path");

    a_respond_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_RESPOND |=> req_ready)
        else $error("controller did not return to idle after a response");
`endif

endmodule

`default_nettype wire
